### rtl/core/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// property that must hold at every clock edge outside reset
`define ASSERT_HOLDS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_HOLDS(lbl, clk, rst_n, prop)
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### rtl/core/lcdnum_pkg.sv
// types, constants and digit helpers for the lcd decimal field writer
package lcdnum_pkg;

    localparam int DEF_MAX_DIGITS  = 5;
    localparam int DEF_QUEUE_DEPTH = 2;
    // decimal positions needed for a 16-bit number
    localparam int NUM_POSITIONS   = 5;

    localparam logic [7:0] CMD_SET_ADDR = 8'h80;
    localparam logic [6:0] ROW0_BASE    = 7'h00;
    localparam logic [6:0] ROW1_BASE    = 7'h40;
    localparam logic [7:0] ASCII_ZERO   = 8'h30;
    localparam logic [3:0] DIGIT_MAX    = 4'd9;

    typedef logic [2:0] pos_t;

    typedef struct packed {
        logic        row;
        logic [3:0]  column;
        logic [15:0] number;
        logic [2:0]  digit_count;
    } req_item_t;

    typedef struct packed {
        logic [7:0] lcd_byte;
        logic       is_data;
        logic       last;
    } lcd_item_t;

    // classified request as held in the queue
    typedef struct packed {
        logic [7:0]  cmd_byte;
        logic [15:0] number;
        logic [2:0]  digit_count;
    } q_entry_t;

    // queue head as seen by the back end
    typedef struct packed {
        logic     valid;
        q_entry_t entry;
    } q_head_t;

    typedef struct packed {
        logic [3:0]  digit;
        logic [15:0] rem;
    } dec_step_t;

    // weight of a decimal position, position 1 is the units
    function automatic logic [16:0] pow10(input pos_t pos);
        logic [16:0] p;
        case (pos)
            3'd1:    p = 17'd1;
            3'd2:    p = 17'd10;
            3'd3:    p = 17'd100;
            3'd4:    p = 17'd1000;
            3'd5:    p = 17'd10000;
            default: p = 17'd1;
        endcase
        return p;
    endfunction

    // one decimal digit off the top of a remainder below ten times the weight
    function automatic dec_step_t dec_step(input logic [15:0] rem, input pos_t pos);
        logic [16:0] p;
        logic [16:0] thr;
        logic [16:0] sub;
        logic [16:0] diff;
        logic [3:0]  d;
        dec_step_t   r;
        p   = pow10(pos);
        sub = '0;
        d   = '0;
        for (int k = 1; k <= 9; k++)
        begin
            thr = 17'(k) * p;
            if ({1'b0, rem} >= thr)
            begin
                d   = 4'(k);
                sub = thr;
            end
        end
        diff    = {1'b0, rem} - sub;
        r.digit = d;
        r.rem   = diff[15:0];
        return r;
    endfunction

endpackage

### rtl/core/char_lcd_decimal_field_writer.sv
// top level of the lcd decimal field writer: front end, queue and back end
//
//  channel   | direction | payload     | handshake
//  request   | in        | req_item_t  | request_valid / request_stall
//  lcd       | out       | lcd_item_t  | lcd_valid / lcd_stall
//
// each request gives one command byte and then one byte per digit shown
// in the back end the command byte goes first, alone when no digits are asked for; then
// the digit unit works down the five decimal positions of a 16-bit number, one a cycle
// the front end queues up to QUEUE_DEPTH classified requests while the back end is busy
// reset empties the queue and the output register, nothing else needs clearing
// a stalled output holds its byte, and the back end waits on it only for bytes it shows
module char_lcd_decimal_field_writer #(
    parameter int MAX_DIGITS  = lcdnum_pkg::DEF_MAX_DIGITS,
    parameter int QUEUE_DEPTH = lcdnum_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  request_valid,
    output logic                  request_stall,
    input  lcdnum_pkg::req_item_t request,
    output logic                  lcd_valid,
    input  logic                  lcd_stall,
    output lcdnum_pkg::lcd_item_t lcd
);
    import lcdnum_pkg::*;

    q_head_t q_head;
    logic    q_pop;

    // request intake and queue
    lcdnum_front #(
        .MAX_DIGITS  (MAX_DIGITS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .request_valid (request_valid),
        .request_stall (request_stall),
        .request       (request),
        .q_head        (q_head),
        .q_pop         (q_pop)
    );

    // byte sequencer and digit unit
    lcdnum_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .lcd_valid (lcd_valid),
        .lcd_stall (lcd_stall),
        .lcd       (lcd)
    );

endmodule

### rtl/core/lcdnum_front.sv
// front end: takes requests, builds the address command and queues them
`include "assert_macros.svh"

module lcdnum_front #(
    parameter int MAX_DIGITS  = lcdnum_pkg::DEF_MAX_DIGITS,
    parameter int QUEUE_DEPTH = lcdnum_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  request_valid,
    output logic                  request_stall,
    input  lcdnum_pkg::req_item_t request,
    output lcdnum_pkg::q_head_t   q_head,
    input  logic                  q_pop
);
    import lcdnum_pkg::*;

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    q_entry_t             store_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0]    fill_reg, fill_next;
    q_entry_t             new_entry;
    logic [6:0]           addr;
    logic                 push;
    logic                 full;

    // classify: address command and clamped digit count
    always_comb
    begin
        addr = (request.row ? ROW1_BASE : ROW0_BASE) + {3'b000, request.column};
        new_entry.cmd_byte = CMD_SET_ADDR | {1'b0, addr};
        new_entry.number   = request.number;
        if (request.digit_count > 3'(MAX_DIGITS))
            new_entry.digit_count = 3'(MAX_DIGITS);
        else
            new_entry.digit_count = request.digit_count;
    end

    // queue control
    assign full          = (fill_reg == FILL_W'(QUEUE_DEPTH));
    assign request_stall = full;
    assign push          = request_valid && !full;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (q_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !q_pop)
            fill_next = fill_reg + 1'b1;
        else if (q_pop && !push)
            fill_next = fill_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
            store_reg[wr_ptr_reg] <= new_entry;
    end

    assign q_head.valid = (fill_reg != '0);
    assign q_head.entry = store_reg[rd_ptr_reg];

    `ASSERT_HOLDS(a_fill_bound, clk, rst_n, fill_reg <= FILL_W'(QUEUE_DEPTH))
    `ASSERT_IMPL(a_head_count, clk, rst_n, q_head.valid, q_head.entry.digit_count <= 3'(MAX_DIGITS))
    `ASSERT_NEXT(a_pop_drains, clk, rst_n, q_pop && !push, fill_reg == $past(fill_reg) - 1'b1)

endmodule

### rtl/core/lcdnum_back.sv
// back end: address command, then digits a position a cycle unless stalled
`include "assert_macros.svh"

module lcdnum_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lcdnum_pkg::q_head_t   q_head,
    output logic                  q_pop,
    output logic                  lcd_valid,
    input  logic                  lcd_stall,
    output lcdnum_pkg::lcd_item_t lcd
);
    import lcdnum_pkg::*;

    typedef enum logic [1:0] {
        ST_CMD = 2'b01,
        ST_DIG = 2'b10
    } state_t;

    state_t      state_reg, state_next;
    pos_t        pos_reg, pos_next;
    logic [15:0] rem_reg, rem_next;
    logic        out_valid_reg, out_valid_next;
    lcd_item_t   out_reg, out_next;
    logic        slot_free;
    logic        load;
    logic        shown;
    dec_step_t   step;
    logic        pos_in_range;
    logic        digit_in_range;

    assign slot_free = !out_valid_reg || !lcd_stall;
    assign step      = dec_step(rem_reg, pos_reg);
    assign shown     = (pos_reg <= q_head.entry.digit_count);

    // sequencer: command, then decimal positions from the top down
    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        rem_next   = rem_reg;
        out_next   = out_reg;
        load       = 1'b0;
        q_pop      = 1'b0;
        case (state_reg)
            ST_CMD:
            begin
                if (q_head.valid && slot_free)
                begin
                    load             = 1'b1;
                    out_next.lcd_byte = q_head.entry.cmd_byte;
                    out_next.is_data  = 1'b0;
                    out_next.last     = (q_head.entry.digit_count == '0);
                    pos_next         = pos_t'(NUM_POSITIONS);
                    rem_next         = q_head.entry.number;
                    if (q_head.entry.digit_count == '0)
                        q_pop = 1'b1;
                    else
                        state_next = ST_DIG;
                end
            end
            ST_DIG:
            begin
                // positions above the requested count are dropped silently
                if (!shown)
                begin
                    rem_next = step.rem;
                    pos_next = pos_reg - 1'b1;
                end
                else if (slot_free)
                begin
                    load              = 1'b1;
                    out_next.lcd_byte = ASCII_ZERO + {4'b0000, step.digit};
                    out_next.is_data  = 1'b1;
                    out_next.last     = (pos_reg == 3'd1);
                    rem_next          = step.rem;
                    pos_next          = pos_reg - 1'b1;
                    if (pos_reg == 3'd1)
                    begin
                        q_pop      = 1'b1;
                        state_next = ST_CMD;
                    end
                end
            end
            default:
            begin
                state_next = ST_CMD;
            end
        endcase
    end

    // output register
    always_comb
    begin
        if (load)
            out_valid_next = 1'b1;
        else if (lcd_stall)
            out_valid_next = out_valid_reg;
        else
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CMD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        rem_reg <= rem_next;
        out_reg <= out_next;
    end

    assign lcd_valid = out_valid_reg;
    assign lcd       = out_reg;

    // terms for the checks below
    assign pos_in_range   = (pos_reg != '0) && (pos_reg <= pos_t'(NUM_POSITIONS));
    assign digit_in_range = (out_reg.lcd_byte >= ASCII_ZERO) &&
                            (out_reg.lcd_byte <= ASCII_ZERO + 8'(DIGIT_MAX));

    `ASSERT_IMPL(a_pop_has_head, clk, rst_n, q_pop, q_head.valid)
    `ASSERT_IMPL(a_dig_has_head, clk, rst_n, state_reg == ST_DIG, q_head.valid)
    `ASSERT_IMPL(a_dig_pos, clk, rst_n, state_reg == ST_DIG, pos_in_range)
    `ASSERT_IMPL(a_digit_range, clk, rst_n, out_valid_reg && out_reg.is_data, digit_in_range)

endmodule
